/* rtl/nrb_pkg.sv */
// nrb_pkg: control word, status and step codes for the n-th root sequencer.
// Holds the microprogram ROM as a function. No dependencies.
`default_nettype none

package nrb_pkg;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_CHECK  = 4'd1;
  localparam step_t ST_LOOP   = 4'd2;
  localparam step_t ST_PTEST  = 4'd3;
  localparam step_t ST_M0     = 4'd4;
  localparam step_t ST_M1     = 4'd5;
  localparam step_t ST_M2     = 4'd6;
  localparam step_t ST_M3     = 4'd7;
  localparam step_t ST_M4     = 4'd8;
  localparam step_t ST_MCHK   = 4'd9;
  localparam step_t ST_DECIDE = 4'd10;
  localparam step_t ST_DONE   = 4'd11;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_RAD_LE1,
    COND_GAP_LE1,
    COND_CNT_ZERO,
    COND_PWR_GE,
    COND_OUT_FREE
  } cond_t;

  // partial-product operand pair: {a half, b half}
  typedef enum logic [1:0] {
    MS_00,
    MS_01,
    MS_10,
    MS_11
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD_H,
    ACC_ADD_2H
  } acc_op_t;

  typedef struct packed {
    cond_t    cond;
    step_t    jmp;        // taken when cond holds
    step_t    alt;        // taken otherwise
    logic     in_rdy;
    logic     ld_in;
    logic     init_bnd;
    logic     start_pass;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     pwr_upd;
    logic     bound_upd;
    logic     out_load;
  } ctl_t;

  typedef struct packed {
    logic rad_le1;
    logic gap_le1;
    logic cnt_zero;
    logic pwr_ge;
    logic out_free;
  } stat_t;

  localparam ctl_t CTL_NOP = '{
    cond: COND_ALWAYS, jmp: ST_IDLE, alt: ST_IDLE, in_rdy: 1'b0, ld_in: 1'b0,
    init_bnd: 1'b0, start_pass: 1'b0, mul_en: 1'b0, mul_sel: MS_00,
    acc_op: ACC_NONE, pwr_upd: 1'b0, bound_upd: 1'b0, out_load: 1'b0
  };

  function automatic ctl_t nrb_rom(input step_t step);
    ctl_t w;
    w = CTL_NOP;
    unique case (step)
      ST_IDLE: begin
        w.cond   = COND_IN_VALID;
        w.jmp    = ST_CHECK;
        w.alt    = ST_IDLE;
        w.in_rdy = 1'b1;
        w.ld_in  = 1'b1;
      end
      ST_CHECK: begin
        w.cond     = COND_RAD_LE1;
        w.jmp      = ST_DONE;
        w.alt      = ST_LOOP;
        w.init_bnd = 1'b1;
      end
      ST_LOOP: begin
        w.cond       = COND_GAP_LE1;
        w.jmp        = ST_DONE;
        w.alt        = ST_PTEST;
        w.start_pass = 1'b1;
      end
      ST_PTEST: begin
        w.cond = COND_CNT_ZERO;
        w.jmp  = ST_DECIDE;
        w.alt  = ST_M0;
      end
      ST_M0: begin
        w.jmp     = ST_M1;
        w.mul_en  = 1'b1;
        w.mul_sel = MS_00;
      end
      ST_M1: begin
        w.jmp     = ST_M2;
        w.mul_en  = 1'b1;
        w.mul_sel = MS_01;
        w.acc_op  = ACC_LOAD;
      end
      ST_M2: begin
        w.jmp     = ST_M3;
        w.mul_en  = 1'b1;
        w.mul_sel = MS_10;
        w.acc_op  = ACC_ADD_H;
      end
      ST_M3: begin
        w.jmp     = ST_M4;
        w.mul_en  = 1'b1;
        w.mul_sel = MS_11;
        w.acc_op  = ACC_ADD_H;
      end
      ST_M4: begin
        w.jmp    = ST_MCHK;
        w.acc_op = ACC_ADD_2H;
      end
      ST_MCHK: begin
        w.cond    = COND_PWR_GE;
        w.jmp     = ST_DECIDE;
        w.alt     = ST_PTEST;
        w.pwr_upd = 1'b1;
      end
      ST_DECIDE: begin
        w.jmp       = ST_LOOP;
        w.bound_upd = 1'b1;
      end
      ST_DONE: begin
        w.cond     = COND_OUT_FREE;
        w.jmp      = ST_IDLE;
        w.alt      = ST_DONE;
        w.out_load = 1'b1;
      end
      default: w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/nrb_ifs.sv */
// nrb_ifs: valid/ready channel interfaces for the n-th root block.
// Input channel carries degree and radicand, output channel carries root.
`default_nettype none

interface nrb_in_if #(
  parameter int DEGREE_BITS   = 6,
  parameter int RADICAND_BITS = 32
);
  logic                     valid;
  logic                     ready;
  logic [DEGREE_BITS-1:0]   degree;
  logic [RADICAND_BITS-1:0] radicand;

  modport source (output valid, output degree, output radicand, input ready);
  modport sink   (input valid, input degree, input radicand, output ready);
endinterface

interface nrb_out_if #(
  parameter int ROOT_BITS = 56
);
  logic                 valid;
  logic                 ready;
  logic [ROOT_BITS-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

/* rtl/nrb_seq.sv */
// nrb_seq: step counter and microprogram ROM with conditional jumps.
// Depends on nrb_pkg (ctl_t, stat_t, nrb_rom).
`default_nettype none

module nrb_seq
  import nrb_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  input  stat_t stat,
  output ctl_t  ctl
);

  step_t step_r, step_nxt;
  logic  cond_hit;

  assign ctl = nrb_rom(step_r);

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_IN_VALID: cond_hit = in_valid;
      COND_RAD_LE1:  cond_hit = stat.rad_le1;
      COND_GAP_LE1:  cond_hit = stat.gap_le1;
      COND_CNT_ZERO: cond_hit = stat.cnt_zero;
      COND_PWR_GE:   cond_hit = stat.pwr_ge;
      COND_OUT_FREE: cond_hit = stat.out_free;
      default:       cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? ctl.jmp : ctl.alt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/nrb_dp.sv */
// nrb_dp: bisection datapath - bounds, power product, shared half-width
// multiplier with accumulator, output register. Depends on nrb_pkg.
`default_nettype none

module nrb_dp
  import nrb_pkg::*;
#(
  parameter int FRAC_BITS     = 24,
  parameter int RADICAND_BITS = 32,
  parameter int DEGREE_BITS   = 6,
  localparam int W            = RADICAND_BITS + FRAC_BITS
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  ctl_t                     ctl,
  input  wire                      in_valid,
  input  wire  [DEGREE_BITS-1:0]   in_degree,
  input  wire  [RADICAND_BITS-1:0] in_radicand,
  input  wire                      out_ready,
  output logic                     out_valid,
  output logic [W-1:0]             out_root,
  output stat_t                    stat
);

  localparam int H   = (W + 1) / 2;   // multiplier half width
  localparam int PPW = 2 * H;         // partial product width
  localparam int AW  = 2 * W;         // full product width
  localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;

  logic [DEGREE_BITS-1:0]   degree_r;
  logic [RADICAND_BITS-1:0] rad_r;
  logic [W-1:0]             low_r, high_r, mid_r, p_r, root_r;
  logic [DEGREE_BITS-1:0]   cnt_r;
  logic                     below_r;
  logic [PPW-1:0]           pp_r;
  logic [AW-1:0]            acc_r;
  logic                     out_valid_r;

  logic [W-1:0]   target, gap;
  logic [W:0]     bsum;
  logic [PPW-1:0] op_a, op_b;
  logic [H-1:0]   mul_a, mul_b;
  logic [AW-1:0]  pp_ext, tgt_sh;
  logic           out_free, pwr_ge;

  assign target = {rad_r, {FRAC_BITS{1'b0}}};
  assign gap    = high_r - low_r;
  assign bsum   = {1'b0, low_r} + {1'b0, high_r};
  assign tgt_sh = {{(AW - RADICAND_BITS - 2 * FRAC_BITS){1'b0}}, rad_r,
                   {(2 * FRAC_BITS){1'b0}}};
  // floor(acc / 2^F) >= target  <=>  acc >= target * 2^F
  assign pwr_ge = acc_r >= tgt_sh;

  assign op_a   = PPW'(p_r);
  assign op_b   = PPW'(mid_r);
  assign pp_ext = AW'(pp_r);

  always_comb begin
    unique case (ctl.mul_sel)
      MS_00: begin mul_a = op_a[H-1:0];   mul_b = op_b[H-1:0];   end
      MS_01: begin mul_a = op_a[H-1:0];   mul_b = op_b[PPW-1:H]; end
      MS_10: begin mul_a = op_a[PPW-1:H]; mul_b = op_b[H-1:0];   end
      MS_11: begin mul_a = op_a[PPW-1:H]; mul_b = op_b[PPW-1:H]; end
      default: begin mul_a = op_a[H-1:0]; mul_b = op_b[H-1:0];   end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  assign stat.rad_le1  = rad_r <= RADICAND_BITS'(1);
  assign stat.gap_le1  = gap <= W'(1);
  assign stat.cnt_zero = cnt_r == '0;
  assign stat.pwr_ge   = pwr_ge;
  assign stat.out_free = out_free;

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.ld_in && in_valid) begin
      degree_r <= in_degree;
      rad_r    <= in_radicand;
    end
    if (ctl.init_bnd) begin
      low_r  <= ONE_FX;
      high_r <= target;
    end
    if (ctl.start_pass) begin
      mid_r   <= bsum[W:1];
      p_r     <= ONE_FX;
      cnt_r   <= degree_r;
      below_r <= 1'b1;
    end
    if (ctl.mul_en) begin
      pp_r <= PPW'(mul_a) * PPW'(mul_b);
    end
    unique case (ctl.acc_op)
      ACC_NONE:   ;
      ACC_LOAD:   acc_r <= pp_ext;
      ACC_ADD_H:  acc_r <= acc_r + (pp_ext << H);
      ACC_ADD_2H: acc_r <= acc_r + (pp_ext << PPW);
      default:    ;
    endcase
    if (ctl.pwr_upd) begin
      if (pwr_ge) begin
        below_r <= 1'b0;
      end else begin
        p_r   <= acc_r[FRAC_BITS +: W];
        cnt_r <= cnt_r - DEGREE_BITS'(1);
      end
    end
    if (ctl.bound_upd) begin
      if (below_r) begin
        low_r <= mid_r;
      end else begin
        high_r <= mid_r;
      end
    end
    if (ctl.out_load && out_free) begin
      root_r <= low_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_root  = root_r;

endmodule

`default_nettype wire

/* rtl/nth_root_bisection.sv */
// nth_root_bisection: n-th root of an integer by bisection, fixed point out.
// Each pass does up to degree multiplies, stopping early once the power
// reaches the target. About RADICAND_BITS+FRAC_BITS passes. Radicand 0 or 1
// skips the search. One item at a time: the next is accepted only once the
// result has loaded and the sequencer is back in idle.
// Reset (sync, active low) returns the step counter to idle, drops out valid.
`default_nettype none

module nth_root_bisection
  import nrb_pkg::*;
#(
  parameter int FRAC_BITS     = 24,
  parameter int RADICAND_BITS = 32,
  parameter int DEGREE_BITS   = 6
) (
  input  wire       clk,
  input  wire       rst_n,
  nrb_in_if.sink    in_ch,
  nrb_out_if.source out_ch
);

  localparam int W = RADICAND_BITS + FRAC_BITS;
  localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;

  ctl_t  ctl;
  stat_t stat;

  // Sequencer walks the microprogram:
  //   idle -> check radicand -> [loop test -> (power test -> 4 partial
  //   products + final add -> compare)* -> pick half]* -> done.
  nrb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath: bounds, mid, running power, multiplier and accumulator.
  // The result sits in an output register, so a new item can enter while
  // the previous result waits.
  nrb_dp #(
    .FRAC_BITS     (FRAC_BITS),
    .RADICAND_BITS (RADICAND_BITS),
    .DEGREE_BITS   (DEGREE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_valid    (in_ch.valid),
    .in_degree   (in_ch.degree),
    .in_radicand (in_ch.radicand),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_root    (out_ch.root),
    .stat        (stat)
  );

  // ready comes from the idle step's control word
  assign in_ch.ready = ctl.in_rdy;

  // ---- assertions ----
  // an accepted item moves the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready still high after accepting an item");

  // the root is never below 1.0
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.root >= ONE_FX))
    else $error("root below 1.0");

  // a new result is only loaded from the done step, never from idle
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result loaded outside the done step");

endmodule

`default_nettype wire

/* tb/tb_nth_root_bisection.sv */
`timescale 1ns / 1ps
// tb_nth_root_bisection: self-checking bench for the bisection n-th root block.
// Needs nrb_pkg, nrb_in_if/nrb_out_if and nth_root_bisection from the rtl folder.

module tb_nth_root_bisection;

  localparam int FRAC_BITS     = 24;
  localparam int RADICAND_BITS = 32;
  localparam int DEGREE_BITS   = 6;
  localparam int ROOT_BITS     = RADICAND_BITS + FRAC_BITS;

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

  // Receiver holds off this long once, after this many roots, so the block
  // finishes its item, parks in its output state and backs up the input.
  localparam int LONG_HOLD    = 30000;
  localparam int LONG_HOLD_AT = 40;
  // No gaps on either side in this window (item / root count).
  localparam int QUIET_LO = 70;
  localparam int QUIET_HI = 100;
  // Random item that waits until every root in flight has come back.
  localparam int DRAIN_AT = 110;
  localparam int N_RANDOM = 141;

  typedef struct {
    logic [DEGREE_BITS-1:0]   degree;
    logic [RADICAND_BITS-1:0] radicand;
    bit                       drain_first;
  } root_req_t;

  typedef struct {
    logic [DEGREE_BITS-1:0]   degree;
    logic [RADICAND_BITS-1:0] radicand;
    logic [ROOT_BITS-1:0]     root;
  } root_due_t;

  logic clk = 1'b0;
  logic rst_n;

  nrb_in_if #(.DEGREE_BITS(DEGREE_BITS), .RADICAND_BITS(RADICAND_BITS)) in_ch ();
  nrb_out_if #(.ROOT_BITS(ROOT_BITS)) out_ch ();

  nth_root_bisection #(
    .FRAC_BITS    (FRAC_BITS),
    .RADICAND_BITS(RADICAND_BITS),
    .DEGREE_BITS  (DEGREE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  root_req_t reqs_waiting[$];   // items not yet accepted
  root_due_t roots_due[$];      // predicted roots, oldest first

  int n_sent;
  int n_roots;
  int n_errors;
  int n_directed;
  int gap_left;
  int stall_left;
  int n_long_holds;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // True if mid^degree, each multiply truncated to FRAC_BITS, stays below
  // target. A product that no longer fits in 64 bits counts as reaching it;
  // the multiplies stop as soon as the product reaches the target.
  function automatic bit power_below(input logic [63:0] mid,
                                     input logic [DEGREE_BITS-1:0] degree,
                                     input logic [63:0] target);
    logic [127:0] prod;
    logic [63:0]  pwr;
    int           i;
    pwr = ONE_FX;
    for (i = 0; i < degree; i++) begin
      prod = {64'd0, pwr} * {64'd0, mid};
      if (prod[127:64+FRAC_BITS] != '0)
        return 1'b0;
      pwr = prod[63+FRAC_BITS:FRAC_BITS];
      if (pwr >= target)
        return 1'b0;
    end
    return pwr < target;
  endfunction

  // Bisection between 1.0 and the radicand; the answer is the low bound.
  // Radicand 0 or 1 skips the search and gives 1.0. Degree 0 makes every
  // power 1.0, so low climbs to one LSB below the radicand.
  function automatic logic [ROOT_BITS-1:0] nth_root_fixed(
      input logic [DEGREE_BITS-1:0] degree, input logic [RADICAND_BITS-1:0] radicand);
    logic [63:0] lo_bnd;
    logic [63:0] hi_bnd;
    logic [63:0] mid;
    logic [63:0] target;
    lo_bnd = ONE_FX;
    if (radicand > 1) begin
      target = {{(64-RADICAND_BITS){1'b0}}, radicand} << FRAC_BITS;
      hi_bnd = target;
      while (hi_bnd - lo_bnd > 64'd1) begin
        mid = (lo_bnd + hi_bnd) >> 1;
        if (power_below(mid, degree, target))
          lo_bnd = mid;
        else
          hi_bnd = mid;
      end
    end
    return lo_bnd[ROOT_BITS-1:0];
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic add_item(input logic [DEGREE_BITS-1:0] degree,
                          input logic [RADICAND_BITS-1:0] radicand,
                          input bit drain_first);
    root_req_t req;
    req.degree      = degree;
    req.radicand    = radicand;
    req.drain_first = drain_first;
    reqs_waiting.push_back(req);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the head of reqs_waiting, predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_items
    int        gap;
    bit        holding;
    root_due_t due;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.degree   <= '0;
      in_ch.radicand <= '0;
      gap_left       <= 0;
    end else begin
      gap     = gap_left;
      holding = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        due.degree   = in_ch.degree;
        due.radicand = in_ch.radicand;
        due.root     = nth_root_fixed(in_ch.degree, in_ch.radicand);
        roots_due.push_back(due);
        void'(reqs_waiting.pop_front());
        n_sent++;
        gap = (n_sent >= QUIET_LO && n_sent < QUIET_HI) ? 0 : pick_gap();
      end
      if (!holding) begin
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap - 1;
        end else if (reqs_waiting.size() != 0 &&
                     !(reqs_waiting[0].drain_first && roots_due.size() != 0)) begin
          in_ch.valid    <= 1'b1;
          in_ch.degree   <= reqs_waiting[0].degree;
          in_ch.radicand <= reqs_waiting[0].radicand;
          gap_left       <= 0;
        end else begin
          // nothing left, or pausing until the block has drained
          in_ch.valid <= 1'b0;
          gap_left    <= 0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each root with the oldest one due
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : collect_roots
    root_due_t want;
    int        stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      stall = stall_left;
      if (out_ch.valid && out_ch.ready) begin
        n_roots++;
        if (roots_due.size() == 0) begin
          n_errors++;
          $display("%0t: root %h with no item outstanding", $time, out_ch.root);
        end else begin
          want = roots_due.pop_front();
          if (out_ch.root !== want.root) begin
            n_errors++;
            $display("%0t: root mismatch, degree %0d radicand %0d: expected %h, got %h",
                     $time, want.degree, want.radicand, want.root, out_ch.root);
          end
        end
        if (n_roots == LONG_HOLD_AT) begin
          stall = LONG_HOLD;
          n_long_holds++;
        end
      end
      if (stall == 0 && !(n_roots >= QUIET_LO && n_roots < QUIET_HI) &&
          $urandom_range(0, 7) == 0)
        stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left   <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : run_main
    int r;
    int k;
    logic [DEGREE_BITS-1:0]   deg;
    logic [RADICAND_BITS-1:0] rad;

    rst_n = 1'b0;

    // Directed: trivial radicands, degree 0 and 1, perfect powers, field
    // extremes, alternating bit patterns, and huge mids that overflow 64 bits.
    add_item(6'd5,  32'd0,          1'b0);
    add_item(6'd0,  32'd0,          1'b0);
    add_item(6'd63, 32'd1,          1'b0);
    add_item(6'd0,  32'd2,          1'b0);
    add_item(6'd0,  32'hFFFF_FFFF,  1'b0);
    add_item(6'd1,  32'd12345,      1'b0);
    add_item(6'd1,  32'hFFFF_FFFF,  1'b0);
    add_item(6'd2,  32'd4,          1'b0);
    add_item(6'd2,  32'd1000000,    1'b0);
    add_item(6'd3,  32'd27,         1'b0);
    add_item(6'd2,  32'hFFFF_FFFF,  1'b0);
    add_item(6'd2,  32'd2,          1'b0);
    add_item(6'd32, 32'hFFFF_FFFF,  1'b0);
    add_item(6'd63, 32'd2,          1'b0);
    add_item(6'd63, 32'hFFFF_FFFF,  1'b0);
    add_item(6'h2A, 32'hAAAA_AAAA,  1'b0);
    add_item(6'h15, 32'h5555_5555,  1'b0);
    add_item(6'd4,  32'd65536,      1'b0);
    add_item(6'd7,  32'h8000_0000,  1'b0);
    n_directed = reqs_waiting.size();

    // Random: mostly low degrees to keep passes short, a few up to 63.
    for (k = 0; k < N_RANDOM; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      deg = DEGREE_BITS'($urandom_range(0, 4));
      else if (r < 85) deg = DEGREE_BITS'($urandom_range(5, 12));
      else if (r < 95) deg = DEGREE_BITS'($urandom_range(13, 31));
      else             deg = DEGREE_BITS'($urandom_range(32, 63));
      r = $urandom_range(0, 99);
      if (r < 30)      rad = $urandom_range(0, 15);
      else if (r < 60) rad = $urandom_range(16, 65535);
      else             rad = $urandom();
      add_item(deg, rad, (n_directed + k) == DRAIN_AT);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_waiting.size() != 0 || roots_due.size() != 0)
      @(posedge clk);
    // catch any stray root after the last one due
    repeat (64) @(posedge clk);

    $display("%0d items sent (%0d directed), %0d roots checked, %0d errors",
             n_sent, n_directed, n_roots, n_errors);
    $display("covered degree 0..63, radicand 0..2^32-1, %0d long output hold(s), drain pause",
             n_long_holds);
    if (n_errors == 0)
      $display("tb_nth_root_bisection passed");
    else
      $display("tb_nth_root_bisection failed");
    $finish;
  end

  // Worst case is every item at degree 63 with a full 32-bit radicand
  // plus stalls; this allows several times that.
  initial begin : watchdog
    #40_000_000;
    $display("%0t: timeout, %0d roots still due", $time, roots_due.size());
    $display("tb_nth_root_bisection failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/nrb_pkg.sv
rtl/nrb_ifs.sv
rtl/nrb_seq.sv
rtl/nrb_dp.sv
rtl/nth_root_bisection.sv
tb/tb_nth_root_bisection.sv
